FILE: rtl/rut_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rut_pkg: shared types and codes for the register usage tracker
// Request kinds, use modes, sequencer states and the layout of one entry of
// the virtual register list.
// ----------------------------------------------------------------------------
package rut_pkg;

   localparam int HANDLE_W = 32;  // virtual register handle / real index
   localparam int MASK_W   = 64;  // width of the reported real masks
   localparam int COUNT_W  = 4;   // width of the reported virtual count

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_READ   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_MODIFY = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      mode_type            mode;
   } entry_type;

endpackage : rut_pkg
`default_nettype wire

FILE: rtl/rut_vlist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rut_vlist: virtual register list storage and handle comparator
// One write port, one read port with registered read data, and the single
// equality compare that the search sequencer reuses every cycle.
// ----------------------------------------------------------------------------
module rut_vlist import rut_pkg::*; #(
   parameter  int DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire entry_type                     wr_data,
   input  wire logic [AW-1:0]                 rd_addr,
   input  wire logic [HANDLE_W-1:0]           key,
   output      entry_type                     rd_data,
   output      logic                          rd_match
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign rd_match = (rd_data_ff.handle == key);

endmodule : rut_vlist
`default_nettype wire

FILE: rtl/register_usage_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// register_usage_tracker: per-instruction register usage table
// Records read, write and modify uses of real registers in two bit masks and
// of virtual registers in a small list searched by handle; answers queries.
// ----------------------------------------------------------------------------
//
//   channel   ports                                        direction
//   -------   ------------------------------------------   ---------
//   req       req_valid / req_stall, kind, use_mode,        in
//             is_virtual, reg_id
//   rsp       rsp_valid / rsp_stall, found, overflow,       out
//             entry_mode, read_bits, write_bits, virtual_count
//
// Timing: a real register, clear or unused-kind transaction goes from accept
//   straight to result. A virtual add or query compares list entries up to
//   and including a hit (all of them on a miss) before its result: the list is
//   walked one entry per cycle through one read port and one handle comparator.
// Reset: synchronous, clears the masks, the entry count and the sequencer.
//   List contents are not cleared; only entries below the count are read.
// Stalls: a result sits in the output register until taken; the next request
//   is accepted meanwhile, and its result waits in ST_RESULT for the slot.
// ----------------------------------------------------------------------------
module register_usage_tracker import rut_pkg::*; #(
   parameter int VIRTUAL_SLOTS = 8,
   parameter int REAL_REGS     = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [1:0]           req_kind,
   input  wire logic [1:0]           req_use_mode,
   input  wire logic                 req_is_virtual,
   input  wire logic [HANDLE_W-1:0]  req_reg_id,
   // response channel
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_found,
   output      logic                 rsp_overflow,
   output      logic [1:0]           rsp_entry_mode,
   output      logic [MASK_W-1:0]    rsp_read_bits,
   output      logic [MASK_W-1:0]    rsp_write_bits,
   output      logic [COUNT_W-1:0]   rsp_virtual_count
);

   localparam int AW = (VIRTUAL_SLOTS > 1) ? $clog2(VIRTUAL_SLOTS) : 1;  // list index
   localparam int CW = $clog2(VIRTUAL_SLOTS + 1);                         // entry count
   localparam int RW = (REAL_REGS > 1) ? $clog2(REAL_REGS) : 1;           // real index

   // ---------------------------------------------------------------- state
   state_type             state_ff, state_in;

   // latched request
   logic [1:0]            kind_ff, kind_in;
   mode_type              mode_ff, mode_in;
   logic                  virt_ff, virt_in;
   logic [HANDLE_W-1:0]   reg_ff, reg_in;

   // search sequencer
   logic [CW-1:0]         idx_ff, idx_in;        // next entry to read
   logic                  pend_ff, pend_in;      // a read is in flight to compare
   logic [AW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  hit_ff, hit_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   mode_type              hit_mode_ff, hit_mode_in;

   // architectural table state
   logic [CW-1:0]         count_ff, count_in;
   logic [REAL_REGS-1:0]  rmask_ff, rmask_in;
   logic [REAL_REGS-1:0]  wmask_ff, wmask_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic                  overflow_ff, overflow_in;
   mode_type              emode_ff, emode_in;
   logic [MASK_W-1:0]     rbits_ff, rbits_in;
   logic [MASK_W-1:0]     wbits_ff, wbits_in;
   logic [COUNT_W-1:0]    vcount_ff, vcount_in;

   // list storage interface
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   entry_type             wr_data;
   entry_type             rd_data;
   logic                  rd_match;

   logic                  req_accept;
   logic                  out_free;
   logic                  scan_more;
   logic                  is_search;
   logic                  real_in_range;
   logic [REAL_REGS-1:0]  reg_bit;

   // ------------------------------------------------------- list storage
   rut_vlist #(
      .DEPTH (VIRTUAL_SLOTS)
   ) u_vlist (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (idx_ff[AW-1:0]),
      .key      (reg_ff),
      .rd_data  (rd_data),
      .rd_match (rd_match)
   );

   // ------------------------------------------------------- common terms
   assign req_accept    = req_valid && !req_stall;
   // The output slot can take a new result when empty or being drained now.
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign scan_more     = (idx_ff < count_ff);
   // Virtual adds and queries walk the list; everything else goes straight on.
   assign is_search     = req_is_virtual &&
                          ((req_kind == KIND_ADD) || (req_kind == KIND_QUERY));
   assign real_in_range = (reg_ff < HANDLE_W'(REAL_REGS));
   assign reg_bit       = REAL_REGS'(1) << reg_ff[RW-1:0];

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = is_search ? ST_SCAN : ST_RESULT;
            end
         end
         ST_SCAN: begin
            // Stop on the first match, or once every held entry was compared.
            if (pend_ff && rd_match) begin
               state_in = ST_RESULT;
            end else if (!scan_more) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------- datapath, outputs
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);

      kind_in      = kind_ff;
      mode_in      = mode_ff;
      virt_in      = virt_ff;
      reg_in       = reg_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_mode_in  = hit_mode_ff;
      count_in     = count_ff;
      rmask_in     = rmask_ff;
      wmask_in     = wmask_ff;

      // Drop the held result once taken; a new one may replace it below.
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      found_in     = found_ff;
      overflow_in  = overflow_ff;
      emode_in     = emode_ff;
      rbits_in     = rbits_ff;
      wbits_in     = wbits_ff;
      vcount_in    = vcount_ff;

      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_data      = '{handle: reg_ff, mode: mode_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_kind;
               // An unused mode code counts as modify.
               mode_in = (req_use_mode == MODE_READ)  ? MODE_READ :
                         (req_use_mode == MODE_WRITE) ? MODE_WRITE : MODE_MODIFY;
               virt_in = req_is_virtual;
               reg_in  = req_reg_id;
               idx_in  = '0;
               pend_in = 1'b0;
               hit_in  = 1'b0;
            end
         end

         ST_SCAN: begin
            if (pend_ff && rd_match) begin
               // Hold the matching slot and its stored mode.
               hit_in      = 1'b1;
               hit_idx_in  = cmp_idx_ff;
               hit_mode_in = rd_data.mode;
               pend_in     = 1'b0;
            end else if (scan_more) begin
               // Issue the next read; its data is compared next cycle.
               pend_in    = 1'b1;
               cmp_idx_in = idx_ff[AW-1:0];
               idx_in     = idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               found_in    = 1'b0;
               overflow_in = 1'b0;
               emode_in    = MODE_READ;

               if (kind_ff == KIND_CLEAR) begin
                  count_in = '0;
                  rmask_in = '0;
                  wmask_in = '0;
               end else if ((kind_ff == KIND_ADD) || (kind_ff == KIND_QUERY)) begin
                  if (virt_ff) begin
                     if (hit_ff) begin
                        found_in = 1'b1;
                        emode_in = hit_mode_ff;
                        // An add with a differing mode promotes the entry to modify.
                        if ((kind_ff == KIND_ADD) && (hit_mode_ff != mode_ff)) begin
                           emode_in = MODE_MODIFY;
                           wr_en    = 1'b1;
                           wr_addr  = hit_idx_ff;
                           wr_data  = '{handle: reg_ff, mode: MODE_MODIFY};
                        end
                     end else if (kind_ff == KIND_ADD) begin
                        if (count_ff < CW'(VIRTUAL_SLOTS)) begin
                           // Append the new handle at the end of the list.
                           wr_en    = 1'b1;
                           wr_addr  = count_ff[AW-1:0];
                           wr_data  = '{handle: reg_ff, mode: mode_ff};
                           count_in = count_ff + CW'(1);
                           emode_in = mode_ff;
                        end else begin
                           overflow_in = 1'b1;
                        end
                     end
                  end else if (real_in_range) begin
                     found_in = |((rmask_ff | wmask_ff) & reg_bit);
                     if (kind_ff == KIND_ADD) begin
                        if (mode_ff != MODE_WRITE) begin
                           rmask_in = rmask_ff | reg_bit;
                        end
                        if (mode_ff != MODE_READ) begin
                           wmask_in = wmask_ff | reg_bit;
                        end
                     end
                  end
               end

               rsp_valid_in = 1'b1;
               rbits_in     = MASK_W'(rmask_in);
               wbits_in     = MASK_W'(wmask_in);
               vcount_in    = COUNT_W'(count_in);
            end
         end

         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         idx_ff       <= '0;
         count_ff     <= '0;
         rmask_ff     <= '0;
         wmask_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rmask_ff     <= rmask_in;
         wmask_ff     <= wmask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      mode_ff     <= mode_in;
      virt_ff     <= virt_in;
      reg_ff      <= reg_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_mode_ff <= hit_mode_in;
      found_ff    <= found_in;
      overflow_ff <= overflow_in;
      emode_ff    <= emode_in;
      rbits_ff    <= rbits_in;
      wbits_ff    <= wbits_in;
      vcount_ff   <= vcount_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_overflow      = overflow_ff;
   assign rsp_entry_mode    = emode_ff;
   assign rsp_read_bits     = rbits_ff;
   assign rsp_write_bits    = wbits_ff;
   assign rsp_virtual_count = vcount_ff;

endmodule : register_usage_tracker
`default_nettype wire

FILE: rtl/rut_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rut_checker: port-level checks for the register usage tracker
// Watches the request and response ports and flags results that the tracker
// can never legally produce.
// ----------------------------------------------------------------------------
module rut_checker import rut_pkg::*; #(
   parameter int VIRTUAL_SLOTS = 8
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic                 rsp_found,
   input wire logic                 rsp_overflow,
   input wire logic [1:0]           rsp_entry_mode,
   input wire logic [MASK_W-1:0]    rsp_read_bits,
   input wire logic [MASK_W-1:0]    rsp_write_bits,
   input wire logic [COUNT_W-1:0]   rsp_virtual_count
);

   // After acceptance, every transaction stalls the request channel while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous transaction in progress");

   // The list never holds more entries than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((VIRTUAL_SLOTS > 15) ||
                     (rsp_virtual_count <= COUNT_W'(VIRTUAL_SLOTS))))
      else $error("virtual count beyond list size");

   // An overflow only happens on a full list and reports no entry.
   a_overflow_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (!rsp_found && (rsp_entry_mode == MODE_READ) &&
          ((VIRTUAL_SLOTS > 15) || (rsp_virtual_count == COUNT_W'(VIRTUAL_SLOTS)))))
      else $error("overflow reported with entry or non-full list");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_overflow) &&
          $stable(rsp_entry_mode) && $stable(rsp_read_bits) &&
          $stable(rsp_write_bits) && $stable(rsp_virtual_count)))
      else $error("stalled response changed");

endmodule : rut_checker

bind register_usage_tracker rut_checker #(
   .VIRTUAL_SLOTS (VIRTUAL_SLOTS)
) u_rut_checker (.*);
`default_nettype wire
